// ===== rtl/amof_pkg.sv =====
// Package: shared types and codes for the 6502 addressing-mode operand fetch block.
`timescale 1ns / 1ps

package amof_pkg;

  localparam int ADDR_W = 16;
  localparam int BYTE_W = 8;
  localparam int MODE_W = 4;
  localparam int STEP_W = 3;
  localparam int KIND_W = 2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_REQ  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DONE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERR  = 2'd2;

  // Commands
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  // Addressing modes
  localparam logic [MODE_W-1:0] MODE_IMM  = 4'd0;
  localparam logic [MODE_W-1:0] MODE_ZP   = 4'd1;
  localparam logic [MODE_W-1:0] MODE_ZPX  = 4'd2;
  localparam logic [MODE_W-1:0] MODE_ZPY  = 4'd3;
  localparam logic [MODE_W-1:0] MODE_ABS  = 4'd4;
  localparam logic [MODE_W-1:0] MODE_ABSX = 4'd5;
  localparam logic [MODE_W-1:0] MODE_ABSY = 4'd6;
  localparam logic [MODE_W-1:0] MODE_IND  = 4'd7;
  localparam logic [MODE_W-1:0] MODE_REL  = 4'd8;
  localparam logic [MODE_W-1:0] MODE_IZX  = 4'd9;
  localparam logic [MODE_W-1:0] MODE_IZY  = 4'd10;
  localparam logic [MODE_W-1:0] MODE_LAST = MODE_IZY;

  // Sequencer steps
  localparam logic [STEP_W-1:0] STEP_0 = 3'd0;
  localparam logic [STEP_W-1:0] STEP_1 = 3'd1;
  localparam logic [STEP_W-1:0] STEP_2 = 3'd2;
  localparam logic [STEP_W-1:0] STEP_3 = 3'd3;

  typedef struct packed {
    logic              cmd;
    logic [MODE_W-1:0] mode;
    logic [ADDR_W-1:0] pc;
    logic [BYTE_W-1:0] index_x;
    logic [BYTE_W-1:0] index_y;
    logic [BYTE_W-1:0] read_data;
  } item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] bus_address;
    logic [ADDR_W-1:0] result_value;
  } result_t;

  typedef struct packed {
    logic              busy;
    logic [MODE_W-1:0] active_mode;
    logic [STEP_W-1:0] step;
    logic [ADDR_W-1:0] saved_pc;
    logic [BYTE_W-1:0] saved_x;
    logic [BYTE_W-1:0] saved_y;
    logic [ADDR_W-1:0] work_address;
  } seq_state_t;

endpackage

// ===== rtl/amof_ifs.sv =====
// Interfaces: command and response channels of the operand fetch block.
`timescale 1ns / 1ps

interface amof_cmd_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [3:0]  mode;
  logic [15:0] pc;
  logic [7:0]  index_x;
  logic [7:0]  index_y;
  logic [7:0]  read_data;

  modport source (output valid, cmd, mode, pc, index_x, index_y, read_data, input ready);
  modport sink   (input valid, cmd, mode, pc, index_x, index_y, read_data, output ready);
endinterface

interface amof_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] bus_address;
  logic [15:0] result_value;

  modport source (output valid, kind, bus_address, result_value, input ready);
  modport sink   (input valid, kind, bus_address, result_value, output ready);
endinterface

// ===== rtl/amof_step.sv =====
// Step logic: next sequencer state and result for one transaction.
`timescale 1ns / 1ps

module amof_step
  import amof_pkg::*;
(
  input  seq_state_t st,
  input  item_t      item,
  output seq_state_t st_next,
  output result_t    res
);

  logic [BYTE_W-1:0] d;
  logic [BYTE_W-1:0] off_zp;
  logic [BYTE_W-1:0] off_abs;
  logic [BYTE_W-1:0] off_ind;
  logic [ADDR_W-1:0] abs_addr;
  logic [ADDR_W-1:0] ind_addr;

  assign d = item.read_data;

  always_comb begin
    off_zp = '0;
    if (st.active_mode == MODE_ZPX) begin
      off_zp = st.saved_x;
    end else if (st.active_mode == MODE_ZPY) begin
      off_zp = st.saved_y;
    end
    off_abs = '0;
    if (st.active_mode == MODE_ABSX) begin
      off_abs = st.saved_x;
    end else if (st.active_mode == MODE_ABSY) begin
      off_abs = st.saved_y;
    end
    off_ind = (st.active_mode == MODE_IZY) ? st.saved_y : '0;
  end

  assign abs_addr = {d, st.work_address[BYTE_W-1:0]} + {{(ADDR_W-BYTE_W){1'b0}}, off_abs};
  assign ind_addr = {d, st.saved_pc[BYTE_W-1:0]} + {{(ADDR_W-BYTE_W){1'b0}}, off_ind};

  always_comb begin
    st_next = st;
    res     = '{kind: KIND_ERR, bus_address: '0, result_value: '0};

    if (item.cmd == CMD_START) begin
      // Refuse a start while busy or with an unknown mode; state stays as is
      if (!st.busy && item.mode <= MODE_LAST) begin
        st_next.busy         = 1'b1;
        st_next.active_mode  = item.mode;
        st_next.step         = STEP_0;
        st_next.saved_pc     = item.pc;
        st_next.saved_x      = item.index_x;
        st_next.saved_y      = item.index_y;
        st_next.work_address = '0;
        res.kind             = KIND_REQ;
        res.bus_address      = item.pc + 16'd1;
      end
    end else if (st.busy) begin
      // Default: protocol slip, drop back to idle
      st_next.busy = 1'b0;
      st_next.step = STEP_0;
      unique case (st.active_mode)
        MODE_IMM: begin
          if (st.step == STEP_0) begin
            res.kind         = KIND_DONE;
            res.result_value = {8'h00, d};
          end
        end
        MODE_ZP, MODE_ZPX, MODE_ZPY: begin
          if (st.step == STEP_0) begin
            st_next.busy         = 1'b1;
            st_next.step         = STEP_1;
            st_next.work_address = {8'h00, d + off_zp};
            res.kind             = KIND_REQ;
            res.bus_address      = {8'h00, d + off_zp};
          end else if (st.step == STEP_1) begin
            res.kind         = KIND_DONE;
            res.result_value = {8'h00, d};
          end
        end
        MODE_ABS, MODE_ABSX, MODE_ABSY, MODE_IND: begin
          if (st.step == STEP_0) begin
            st_next.busy         = 1'b1;
            st_next.step         = STEP_1;
            st_next.work_address = {8'h00, d};
            res.kind             = KIND_REQ;
            res.bus_address      = st.saved_pc + 16'd2;
          end else if (st.step == STEP_1) begin
            st_next.busy         = 1'b1;
            st_next.step         = STEP_2;
            st_next.work_address = abs_addr;
            res.kind             = KIND_REQ;
            res.bus_address      = abs_addr;
          end else if (st.step == STEP_2) begin
            if (st.active_mode != MODE_IND) begin
              res.kind         = KIND_DONE;
              res.result_value = {8'h00, d};
            end else begin
              st_next.busy     = 1'b1;
              st_next.step     = STEP_3;
              st_next.saved_pc = {8'h00, d};
              res.kind         = KIND_REQ;
              res.bus_address  = st.work_address + 16'd1;
            end
          end else if (st.step == STEP_3 && st.active_mode == MODE_IND) begin
            res.kind         = KIND_DONE;
            res.result_value = {d, st.saved_pc[BYTE_W-1:0]};
          end
        end
        MODE_REL: begin
          if (st.step == STEP_0) begin
            res.kind         = KIND_DONE;
            res.result_value = st.saved_pc + 16'd2 + {{BYTE_W{d[BYTE_W-1]}}, d};
          end
        end
        MODE_IZX, MODE_IZY: begin
          if (st.step == STEP_0) begin
            st_next.busy         = 1'b1;
            st_next.step         = STEP_1;
            st_next.work_address = {8'h00, d + ((st.active_mode == MODE_IZX) ? st.saved_x : 8'h00)};
            res.kind             = KIND_REQ;
            res.bus_address      = st_next.work_address;
          end else if (st.step == STEP_1) begin
            // Pointer high byte wraps within the zero page
            st_next.busy     = 1'b1;
            st_next.step     = STEP_2;
            st_next.saved_pc = {8'h00, d};
            res.kind         = KIND_REQ;
            res.bus_address  = {8'h00, st.work_address[BYTE_W-1:0] + 8'd1};
          end else if (st.step == STEP_2) begin
            st_next.busy         = 1'b1;
            st_next.step         = STEP_3;
            st_next.work_address = ind_addr;
            res.kind             = KIND_REQ;
            res.bus_address      = ind_addr;
          end else if (st.step == STEP_3) begin
            res.kind         = KIND_DONE;
            res.result_value = {8'h00, d};
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/amof_out_reg.sv =====
// Result register: holds one response transaction until the sink takes it.
`timescale 1ns / 1ps

module amof_out_reg
  import amof_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load_valid,
  input  result_t    load_data,
  output logic       load_ready,
  amof_rsp_if.source rsp
);

  logic    valid;
  result_t data;

  assign load_ready = !valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load_ready) begin
      valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ready && load_valid) begin
      data <= load_data;
    end
  end

  assign rsp.valid        = valid;
  assign rsp.kind         = data.kind;
  assign rsp.bus_address  = data.bus_address;
  assign rsp.result_value = data.result_value;

endmodule

// ===== rtl/addressing_mode_operand_fetch.sv =====
// Top level: 6502 addressing-mode operand fetch sequencer.
//
//   channel    dir   payload                                        role
//   cmd_chan   in    cmd, mode, pc, index_x, index_y, read_data     start or bus byte
//   rsp_chan   out   kind, bus_address, result_value                request, done, error
//
// Every transaction gives one response, registered first in the input register and then
// in the result register; one transaction per cycle is sustained while rsp_chan is not stalled.
// Reset (rst, synchronous) clears the input and result valid flags and the state.
// A stalled response holds in the result register; the input register then holds,
// and cmd_chan.ready drops only when both are full.
`timescale 1ns / 1ps

module addressing_mode_operand_fetch
  import amof_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  amof_cmd_if.sink   cmd_chan,
  amof_rsp_if.source rsp_chan
);

  logic       s1_valid;
  item_t      s1_item;
  logic       out_ready;
  logic       s1_fire;
  seq_state_t st;
  seq_state_t st_next;
  result_t    step_res;

  assign s1_fire        = s1_valid && out_ready;
  assign cmd_chan.ready = !s1_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd_chan.ready) begin
      s1_valid <= cmd_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_chan.ready && cmd_chan.valid) begin
      s1_item <= '{cmd: cmd_chan.cmd, mode: cmd_chan.mode, pc: cmd_chan.pc,
                   index_x: cmd_chan.index_x, index_y: cmd_chan.index_y,
                   read_data: cmd_chan.read_data};
    end
  end

  // Advance the sequencer only when the transaction moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (s1_fire) begin
      st <= st_next;
    end
  end

  amof_step u_step (
    .st      (st),
    .item    (s1_item),
    .st_next (st_next),
    .res     (step_res)
  );

  amof_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load_valid (s1_valid),
    .load_data  (step_res),
    .load_ready (out_ready),
    .rsp        (rsp_chan)
  );

endmodule

// ===== tb/amof_fetch_checker.sv =====
// Checker: predicts and compares every response of the operand fetch block.
`timescale 1ns / 1ps

module amof_fetch_checker
  import amof_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  amof_cmd_if        cmd_mon,
  amof_rsp_if        rsp_mon,
  output int         mismatches,
  output int         pending
);

  seq_state_t fetch_state;
  result_t    due_responses[$];
  item_t      taken_item;
  result_t    want;
  result_t    got;

  function automatic result_t next_fetch_response(input item_t it);
    result_t           rsp;
    logic [BYTE_W-1:0] d;
    logic [BYTE_W-1:0] off;
    logic [MODE_W-1:0] m;
    logic [STEP_W-1:0] st;
    logic [ADDR_W-1:0] req_addr;
    logic [STEP_W-1:0] req_step;
    logic              asked;
    logic              finished;
    rsp = '{kind: KIND_ERR, bus_address: '0, result_value: '0};
    d = it.read_data;
    m = fetch_state.active_mode;
    st = fetch_state.step;
    req_addr = '0;
    req_step = STEP_0;
    asked = 1'b0;
    finished = 1'b0;
    if (it.cmd == CMD_START) begin
      // a start while busy or with an unknown mode leaves the state alone
      if (!fetch_state.busy && it.mode <= MODE_LAST) begin
        fetch_state = '{busy: 1'b1, active_mode: it.mode, step: STEP_0, saved_pc: it.pc,
                        saved_x: it.index_x, saved_y: it.index_y, work_address: '0};
        rsp.kind = KIND_REQ;
        rsp.bus_address = it.pc + 16'd1;
      end
      return rsp;
    end
    if (!fetch_state.busy) return rsp;
    case (m)
      MODE_IMM: begin
        if (st == STEP_0) begin
          rsp.result_value = {8'h00, d};
          finished = 1'b1;
        end
      end
      MODE_ZP, MODE_ZPX, MODE_ZPY: begin
        if (st == STEP_0) begin
          off = (m == MODE_ZPX) ? fetch_state.saved_x :
                (m == MODE_ZPY) ? fetch_state.saved_y : 8'h00;
          fetch_state.work_address = {8'h00, d + off};
          req_addr = fetch_state.work_address;
          req_step = STEP_1;
          asked = 1'b1;
        end else if (st == STEP_1) begin
          rsp.result_value = {8'h00, d};
          finished = 1'b1;
        end
      end
      MODE_ABS, MODE_ABSX, MODE_ABSY, MODE_IND: begin
        if (st == STEP_0) begin
          fetch_state.work_address = {8'h00, d};
          req_addr = fetch_state.saved_pc + 16'd2;
          req_step = STEP_1;
          asked = 1'b1;
        end else if (st == STEP_1) begin
          off = (m == MODE_ABSX) ? fetch_state.saved_x :
                (m == MODE_ABSY) ? fetch_state.saved_y : 8'h00;
          fetch_state.work_address = (fetch_state.work_address | {d, 8'h00}) + {8'h00, off};
          req_addr = fetch_state.work_address;
          req_step = STEP_2;
          asked = 1'b1;
        end else if (st == STEP_2) begin
          if (m != MODE_IND) begin
            rsp.result_value = {8'h00, d};
            finished = 1'b1;
          end else begin
            // hold the pointer's low byte in place of the PC
            fetch_state.saved_pc = {8'h00, d};
            req_addr = fetch_state.work_address + 16'd1;
            req_step = STEP_3;
            asked = 1'b1;
          end
        end else if (st == STEP_3 && m == MODE_IND) begin
          rsp.result_value = fetch_state.saved_pc | {d, 8'h00};
          finished = 1'b1;
        end
      end
      MODE_REL: begin
        if (st == STEP_0) begin
          rsp.result_value = fetch_state.saved_pc + 16'd2 + {{8{d[7]}}, d};
          finished = 1'b1;
        end
      end
      MODE_IZX, MODE_IZY: begin
        if (st == STEP_0) begin
          off = (m == MODE_IZX) ? fetch_state.saved_x : 8'h00;
          fetch_state.work_address = {8'h00, d + off};
          req_addr = fetch_state.work_address;
          req_step = STEP_1;
          asked = 1'b1;
        end else if (st == STEP_1) begin
          fetch_state.saved_pc = {8'h00, d};
          // pointer high byte stays in the zero page
          req_addr = {8'h00, fetch_state.work_address[7:0] + 8'd1};
          req_step = STEP_2;
          asked = 1'b1;
        end else if (st == STEP_2) begin
          off = (m == MODE_IZY) ? fetch_state.saved_y : 8'h00;
          fetch_state.work_address = (fetch_state.saved_pc | {d, 8'h00}) + {8'h00, off};
          req_addr = fetch_state.work_address;
          req_step = STEP_3;
          asked = 1'b1;
        end else if (st == STEP_3) begin
          rsp.result_value = {8'h00, d};
          finished = 1'b1;
        end
      end
      default: ;
    endcase
    if (asked) begin
      fetch_state.step = req_step;
      rsp.kind = KIND_REQ;
      rsp.bus_address = req_addr;
    end else begin
      fetch_state.busy = 1'b0;
      fetch_state.step = STEP_0;
      rsp.kind = finished ? KIND_DONE : KIND_ERR;
      if (!finished) rsp.result_value = '0;
    end
    return rsp;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      fetch_state = '0;
      due_responses.delete();
      mismatches = 0;
    end else begin
      if (cmd_mon.valid === 1'b1 && cmd_mon.ready === 1'b1) begin
        taken_item = '{cmd: cmd_mon.cmd, mode: cmd_mon.mode, pc: cmd_mon.pc,
                       index_x: cmd_mon.index_x, index_y: cmd_mon.index_y,
                       read_data: cmd_mon.read_data};
        due_responses.push_back(next_fetch_response(taken_item));
      end
      if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
        got = '{kind: rsp_mon.kind, bus_address: rsp_mon.bus_address,
                result_value: rsp_mon.result_value};
        if (due_responses.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: response with nothing due: kind %0d bus_address %h result_value %h",
                     $realtime, got.kind, got.bus_address, got.result_value);
          mismatches++;
        end else begin
          want = due_responses.pop_front();
          if (got.kind !== want.kind || got.bus_address !== want.bus_address ||
              got.result_value !== want.result_value) begin
            if (mismatches < 10)
              $display("%0t: response differs: kind %0d/%0d bus_address %h/%h result_value %h/%h",
                       $realtime, want.kind, got.kind, want.bus_address, got.bus_address,
                       want.result_value, got.result_value);
            mismatches++;
          end
        end
      end
    end
    pending = due_responses.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top: drives the operand fetch block and reports the verdict.
`timescale 1ns / 1ps

module tb_top;
  import amof_pkg::*;

  localparam int                ITEM_TARGET   = 1650;
  localparam logic [MODE_W-1:0] MODE_MAX_CODE = '1;

  logic clk = 1'b0;
  logic rst;
  int   mismatches;
  int   pending;
  int   items_sent = 0;
  bit   feed_burst = 1'b0;
  bit   drain_burst = 1'b0;

  amof_cmd_if cmd_chan ();
  amof_rsp_if rsp_chan ();

  addressing_mode_operand_fetch DUT (
    .clk      (clk),
    .rst      (rst),
    .cmd_chan (cmd_chan),
    .rsp_chan (rsp_chan)
  );

  amof_fetch_checker fetch_chk (
    .clk        (clk),
    .rst        (rst),
    .cmd_mon    (cmd_chan),
    .rsp_mon    (rsp_chan),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [BYTE_W-1:0] rand_byte();
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0: return 8'h00;
        1: return 8'h7F;
        2: return 8'h80;
        default: return 8'hFF;
      endcase
    end
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [ADDR_W-1:0] random_pc();
    if ($urandom_range(0, 7) == 0) return ADDR_W'($urandom_range(16'hFFFD, 16'hFFFF));
    return ADDR_W'($urandom_range(0, 16'hFFFF));
  endfunction

  function automatic item_t random_item();
    item_t it;
    it.cmd = 1'($urandom_range(0, 1));
    it.mode = MODE_W'($urandom_range(0, MODE_MAX_CODE));
    it.pc = random_pc();
    it.index_x = rand_byte();
    it.index_y = rand_byte();
    it.read_data = rand_byte();
    return it;
  endfunction

  // Leave valid high across back-to-back transactions; drop it only for a gap.
  task automatic send_item(input item_t it);
    int gap;
    if ($urandom_range(0, 49) == 0) feed_burst = !feed_burst;
    gap = feed_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      cmd_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_chan.valid     <= 1'b1;
    cmd_chan.cmd       <= it.cmd;
    cmd_chan.mode      <= it.mode;
    cmd_chan.pc        <= it.pc;
    cmd_chan.index_x   <= it.index_x;
    cmd_chan.index_y   <= it.index_y;
    cmd_chan.read_data <= it.read_data;
    @(posedge clk);
    while (!cmd_chan.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic start_fetch(input logic [MODE_W-1:0] m, input logic [ADDR_W-1:0] p,
                             input logic [BYTE_W-1:0] x, input logic [BYTE_W-1:0] y);
    item_t it;
    it = random_item();
    it.cmd = CMD_START;
    it.mode = m;
    it.pc = p;
    it.index_x = x;
    it.index_y = y;
    send_item(it);
  endtask

  task automatic feed_byte(input logic [BYTE_W-1:0] d);
    item_t it;
    it = random_item();
    it.cmd = CMD_DATA;
    it.read_data = d;
    send_item(it);
  endtask

  // Call only at the edge of an accepted transaction: drop valid and drain.
  task automatic drain_all();
    cmd_chan.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  initial begin
    int                r;
    int                beats;
    logic [MODE_W-1:0] m;
    bit                paused;
    paused = 1'b0;
    rst <= 1'b1;
    cmd_chan.valid     <= 1'b0;
    cmd_chan.cmd       <= CMD_START;
    cmd_chan.mode      <= MODE_IMM;
    cmd_chan.pc        <= '0;
    cmd_chan.index_x   <= '0;
    cmd_chan.index_y   <= '0;
    cmd_chan.read_data <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // data while idle, unknown mode
    feed_byte(8'h5A);
    start_fetch(MODE_MAX_CODE, 16'h1234, 8'h01, 8'h02);
    // backward branch across the top of memory
    start_fetch(MODE_REL, 16'hFFFF, 8'h00, 8'h00);
    feed_byte(8'h80);
    // indirect through FFFF, with a start while busy in the middle
    start_fetch(MODE_IND, 16'hFFFE, 8'hFF, 8'hFF);
    feed_byte(8'hFF);
    start_fetch(MODE_IMM, 16'h0000, 8'h00, 8'h00);
    feed_byte(8'hFF);
    feed_byte(8'h12);
    feed_byte(8'h34);
    // (zp,X) with the pointer at the last zero-page byte, so the high-byte fetch wraps
    start_fetch(MODE_IZX, 16'h8000, 8'hFF, 8'h00);
    feed_byte(8'h00);
    feed_byte(8'hAB);
    feed_byte(8'hCD);
    feed_byte(8'hEE);
    // (zp),Y with the pointer at FF and Y wrapping past FFFF
    start_fetch(MODE_IZY, 16'h4000, 8'h00, 8'hFF);
    feed_byte(8'hFF);
    feed_byte(8'hFF);
    feed_byte(8'hFF);
    feed_byte(8'h00);
    // abs,X wrapping past FFFF
    start_fetch(MODE_ABSX, 16'h0000, 8'hFF, 8'h00);
    feed_byte(8'hFF);
    feed_byte(8'hFF);
    feed_byte(8'h00);

    while (items_sent < ITEM_TARGET) begin
      if (!paused && items_sent >= ITEM_TARGET / 2) begin
        drain_all();
        @(posedge clk);
        paused = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 6) begin
        feed_byte(rand_byte());
      end else if (r < 10) begin
        start_fetch(MODE_W'($urandom_range(MODE_LAST + 1, MODE_MAX_CODE)), random_pc(),
                    rand_byte(), rand_byte());
      end else begin
        m = MODE_W'($urandom_range(0, MODE_LAST));
        start_fetch(m, random_pc(), rand_byte(), rand_byte());
        case (m)
          MODE_IMM, MODE_REL:           beats = 1;
          MODE_ZP, MODE_ZPX, MODE_ZPY:  beats = 2;
          MODE_ABS, MODE_ABSX, MODE_ABSY: beats = 3;
          default:                      beats = 4;
        endcase
        for (int b = 0; b < beats; b++) begin
          if ($urandom_range(0, 29) == 0)
            start_fetch(MODE_W'($urandom_range(0, MODE_MAX_CODE)), random_pc(), rand_byte(),
                        rand_byte());
          feed_byte(rand_byte());
        end
      end
    end

    drain_all();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Response side: random stalls per transaction, with stretches of none.
  initial begin
    int stall;
    rsp_chan.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if ($urandom_range(0, 39) == 0) drain_burst = !drain_burst;
      stall = drain_burst ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        rsp_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_chan.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_chan.valid) @(posedge clk);
    end
  end

  initial begin
    #1000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
